// ===== rtl/crs_pkg.sv =====
`default_nettype none
package crs_pkg;

  // Internal precision of the linearization table build, Q0.30.
  localparam int unsigned QB = 30;
  localparam int unsigned TableSize = 256;
  localparam logic [15:0] WRed = 16'd13933;
  localparam logic [15:0] WGreen = 16'd46871;
  localparam logic [15:0] WBlue = 16'd4732;
  localparam longint unsigned QOne = 64'd1 << QB;
  localparam longint unsigned LinDenA = 64'd1292 * 64'd255;
  localparam longint unsigned LinDenB = 64'd1055 * 64'd255;

  // Fixed-point multiply with rounding, Q0.30.
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (QB - 1))) >> QB;
  endfunction

  function automatic longint unsigned qpow5(longint unsigned y);
    longint unsigned y2;
    y2 = qmul(y, y);
    return qmul(qmul(y2, y2), y);
  endfunction

  // One linear-light table entry in Q0.frac, evaluated at elaboration only.
  function automatic logic [31:0] lin_entry(int unsigned c, int unsigned frac);
    longint unsigned cc;
    longint unsigned y;
    longint unsigned v;
    longint unsigned v2;
    longint unsigned v4;
    longint unsigned v12;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned res;
    cc = longint'(c);
    if (cc * 64'd100000 <= 64'd4045 * 64'd255) begin
      y = ((cc * 64'd100) * QOne + (LinDenA >> 1)) / LinDenA;
    end else begin
      v = ((64'd1000 * cc + 64'd55 * 64'd255) * QOne + (LinDenB >> 1)) / LinDenB;
      if (v > QOne) v = QOne;
      v2 = qmul(v, v);
      v4 = qmul(v2, v2);
      v12 = qmul(qmul(v4, v4), v4);
      lo = 0;
      hi = QOne;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (qpow5(mid) <= v12) lo = mid;
        else hi = mid - 64'd1;
      end
      y = lo;
    end
    res = (y + (64'd1 << (QB - 1 - frac))) >> (QB - frac);
    return res[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crs_front.sv =====
`default_nettype none
module crs_front
  import crs_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          first_red_i,
  input  wire logic [7:0]          first_green_i,
  input  wire logic [7:0]          first_blue_i,
  input  wire logic [7:0]          second_red_i,
  input  wire logic [7:0]          second_green_i,
  input  wire logic [7:0]          second_blue_i,
  output logic                     item_valid_o,
  input  wire logic                item_ready_i,
  output logic [FracBits:0]        first_luma_o,
  output logic [FracBits:0]        second_luma_o,
  output logic                     first_lighter_o,
  output logic [FracBits:0]        hi_off_o,
  output logic [FracBits:0]        lo_off_o
);

  localparam int unsigned LW = FracBits + 1;
  localparam int unsigned PW = LW + 16;
  localparam int unsigned SW = PW + 2;
  localparam longint unsigned OffVal = (64'd5 * (64'd1 << FracBits) + 64'd50) / 64'd100;
  localparam logic [LW-1:0] Off = LW'(OffVal);

  // Constant linearization table.
  logic [LW-1:0] lin_tab [TableSize];
  for (genvar g = 0; g < TableSize; g++) begin : g_lin
    localparam logic [31:0] Entry = lin_entry(g, FracBits);
    assign lin_tab[g] = Entry[LW-1:0];
  end

  logic v1_q, v2_q, v3_q;
  logic adv;
  logic [LW-1:0] ch1_q [6];
  logic [PW-1:0] pr2_q [6];
  logic [LW-1:0] l1_q, l2_q;
  logic [SW-1:0] s1, s2;
  logic [SW-1:0] rnd;
  logic [SW-1:0] l1_full, l2_full;

  // The whole front moves together; it stalls only when the queue is full.
  assign adv = !v3_q || item_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage one: table lookups for all six channels.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch1_q[0] <= lin_tab[first_red_i];
      ch1_q[1] <= lin_tab[first_green_i];
      ch1_q[2] <= lin_tab[first_blue_i];
      ch1_q[3] <= lin_tab[second_red_i];
      ch1_q[4] <= lin_tab[second_green_i];
      ch1_q[5] <= lin_tab[second_blue_i];
    end
  end

  // Stage two: weighted products, one multiplier per channel lane.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr2_q[0] <= PW'(ch1_q[0]) * PW'(WRed);
      pr2_q[1] <= PW'(ch1_q[1]) * PW'(WGreen);
      pr2_q[2] <= PW'(ch1_q[2]) * PW'(WBlue);
      pr2_q[3] <= PW'(ch1_q[3]) * PW'(WRed);
      pr2_q[4] <= PW'(ch1_q[4]) * PW'(WGreen);
      pr2_q[5] <= PW'(ch1_q[5]) * PW'(WBlue);
    end
  end

  // Stage three: sum and round each luma.
  assign rnd = SW'(32768);
  assign s1 = SW'(pr2_q[0]) + SW'(pr2_q[1]) + SW'(pr2_q[2]) + rnd;
  assign s2 = SW'(pr2_q[3]) + SW'(pr2_q[4]) + SW'(pr2_q[5]) + rnd;
  assign l1_full = s1 >> 16;
  assign l2_full = s2 >> 16;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q <= l1_full[LW-1:0];
      l2_q <= l2_full[LW-1:0];
    end
  end

  // Order the pair and add the 0.05 offset for the divider.
  assign first_lighter_o = l1_q > l2_q;
  assign first_luma_o = l1_q;
  assign second_luma_o = l2_q;
  assign hi_off_o = (first_lighter_o ? l1_q : l2_q) + Off;
  assign lo_off_o = (first_lighter_o ? l2_q : l1_q) + Off;
  assign item_valid_o = v3_q;

endmodule
`default_nettype wire

// ===== rtl/crs_fifo.sv =====
`default_nettype none
module crs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = cnt_q != CW'(Depth);
  assign pop_valid_o = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth)) else $error("queue count above depth");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_ready_o && !pop_ready_i) |=> (cnt_q == CW'(Depth)))
    else $error("full queue lost a beat");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !push_valid_i) |=> !pop_valid_o)
    else $error("queue shows data it never took");

endmodule
`default_nettype wire

// ===== rtl/crs_back.sv =====
`default_nettype none
module crs_back #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  output logic                     item_ready_o,
  input  wire logic [FracBits:0]   first_luma_i,
  input  wire logic [FracBits:0]   second_luma_i,
  input  wire logic                first_lighter_i,
  input  wire logic [FracBits:0]   hi_off_i,
  input  wire logic [FracBits:0]   lo_off_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [FracBits+4:0]      contrast_o,
  output logic [FracBits:0]        first_luma_o,
  output logic [FracBits:0]        second_luma_o,
  output logic                     first_is_lighter_o
);

  localparam int unsigned LW = FracBits + 1;
  localparam int unsigned QW = FracBits + 5;
  localparam int unsigned NW = 2 * FracBits + 2;
  localparam int unsigned RW = FracBits + 1;
  localparam logic [QW-1:0] Cap = QW'(21) << FracBits;

  logic adv;
  logic [NW-1:0] num;
  logic v_q [QW];
  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] nlo_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [RW-1:0] den_q [QW];
  logic [LW-1:0] l1_q [QW];
  logic [LW-1:0] l2_q [QW];
  logic fl_q [QW];

  // Dividend with half the divisor added, so the quotient rounds half up.
  assign num = (NW'(hi_off_i) << FracBits) + NW'(lo_off_i >> 1);
  assign adv = !v_q[QW-1] || out_ready_i;
  assign item_ready_o = adv;

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] nlo_in;
    logic [QW-1:0] quo_in;
    logic [RW-1:0] den_in;
    logic          v_in;
    logic [LW-1:0] l1_in;
    logic [LW-1:0] l2_in;
    logic          fl_in;
    logic [RW:0] trial;
    logic take;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num[NW-1:QW]);
      assign nlo_in = num[QW-1:0];
      assign quo_in = '0;
      assign den_in = lo_off_i;
      assign v_in = item_valid_i;
      assign l1_in = first_luma_i;
      assign l2_in = second_luma_i;
      assign fl_in = first_lighter_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nlo_in = nlo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign v_in = v_q[k-1];
      assign l1_in = l1_q[k-1];
      assign l2_in = l2_q[k-1];
      assign fl_in = fl_q[k-1];
    end

    assign trial = {rem_in, nlo_in[QW-1]};
    assign take = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k] <= take ? RW'(trial - {1'b0, den_in}) : RW'(trial);
        nlo_q[k] <= nlo_in << 1;
        quo_q[k] <= {quo_in[QW-2:0], take};
        den_q[k] <= den_in;
        l1_q[k] <= l1_in;
        l2_q[k] <= l2_in;
        fl_q[k] <= fl_in;
      end
    end
  end

  // Saturate at 21.0 and drive the result beat.
  assign out_valid_o = v_q[QW-1];
  assign contrast_o = (quo_q[QW-1] > Cap) ? Cap : quo_q[QW-1];
  assign first_luma_o = l1_q[QW-1];
  assign second_luma_o = l2_q[QW-1];
  assign first_is_lighter_o = fl_q[QW-1];

  a_ratio_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (contrast_o >= (QW'(1) << FracBits)))
    else $error("contrast below 1.0");
  a_lighter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_is_lighter_o == (first_luma_o > second_luma_o)))
    else $error("lighter flag disagrees with lumas");
  a_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && first_luma_o == second_luma_o) |->
    (contrast_o == (QW'(1) << FracBits)))
    else $error("equal lumas must give 1.0");

endmodule
`default_nettype wire

// ===== rtl/contrast_ratio_srgb_top.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   first_/second_ red, green, blue (8 bits each)
// out      out_valid_o / out_ready_i contrast_o, first_luma_o, second_luma_o,
//                                    first_is_lighter_o
//
// One beat is taken per cycle unless the front stalls; beats pass 3 front
// stages, the queue, FRAC_BITS+5 divider stages (one restoring quotient bit each).
// The fully pipelined divider sets throughput: one pair per cycle unless stalled.
// Reset is asynchronous, active low, and clears valid state and queue pointers.
// The front stalls only when the queue is full; the divider stalls only
// when its last stage holds a beat that out_ready_i does not take.
`default_nettype none
module contrast_ratio_srgb_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           first_red_i,
  input  wire logic [7:0]           first_green_i,
  input  wire logic [7:0]           first_blue_i,
  input  wire logic [7:0]           second_red_i,
  input  wire logic [7:0]           second_green_i,
  input  wire logic [7:0]           second_blue_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [FRAC_BITS+4:0]      contrast_o,
  output logic [FRAC_BITS:0]        first_luma_o,
  output logic [FRAC_BITS:0]        second_luma_o,
  output logic                      first_is_lighter_o
);

  localparam int unsigned LW = FRAC_BITS + 1;
  localparam int unsigned IW = 4 * LW + 1;

  logic f_valid, f_ready, b_valid, b_ready;
  logic [LW-1:0] f_l1, f_l2, f_hi, f_lo;
  logic f_fl;
  logic [IW-1:0] f_data, b_data;

  crs_front #(.FracBits(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_red_i, .first_green_i, .first_blue_i,
    .second_red_i, .second_green_i, .second_blue_i,
    .item_valid_o(f_valid), .item_ready_i(f_ready),
    .first_luma_o(f_l1), .second_luma_o(f_l2), .first_lighter_o(f_fl),
    .hi_off_o(f_hi), .lo_off_o(f_lo)
  );

  assign f_data = {f_l1, f_l2, f_fl, f_hi, f_lo};

  crs_fifo #(.Width(IW), .Depth(4)) u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_data),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(b_data)
  );

  crs_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i(b_valid), .item_ready_o(b_ready),
    .first_luma_i(b_data[IW-1 -: LW]),
    .second_luma_i(b_data[IW-1-LW -: LW]),
    .first_lighter_i(b_data[2*LW]),
    .hi_off_i(b_data[2*LW-1 -: LW]),
    .lo_off_i(b_data[LW-1:0]),
    .out_valid_o, .out_ready_i, .contrast_o,
    .first_luma_o, .second_luma_o, .first_is_lighter_o
  );

endmodule
`default_nettype wire

// ===== sim/contrast_ratio_srgb_checker.sv =====
`default_nettype none
module contrast_ratio_srgb_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic [7:0]           first_red_i,
  input  wire logic [7:0]           first_green_i,
  input  wire logic [7:0]           first_blue_i,
  input  wire logic [7:0]           second_red_i,
  input  wire logic [7:0]           second_green_i,
  input  wire logic [7:0]           second_blue_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic [FRAC_BITS+4:0] contrast_i,
  input  wire logic [FRAC_BITS:0]   first_luma_i,
  input  wire logic [FRAC_BITS:0]   second_luma_i,
  input  wire logic                 first_is_lighter_i,
  output int                        err_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [FRAC_BITS+4:0] contrast;
    logic [FRAC_BITS:0]   luma_a;
    logic [FRAC_BITS:0]   luma_b;
    logic                 a_lighter;
  } ratio_t;

  localparam longint unsigned Unity = 64'd1 << 30;

  longint unsigned gamma_lut [256];
  ratio_t          ratio_q [$];

  // Rounded product of two Q0.30 values.
  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Linear-light value of one sRGB code, in Q0.FRAC_BITS.
  function automatic longint unsigned decode_srgb(int unsigned code);
    longint unsigned c, lin, base, sq, quad, twelfth, lo, hi, mid, m2, m5;
    c = code;
    if (c * 100000 <= 64'd4045 * 255) begin
      lin = (c * 100 * Unity + (64'd1292 * 255) / 2) / (64'd1292 * 255);
    end else begin
      base = ((1000 * c + 55 * 255) * Unity + (64'd1055 * 255) / 2) / (64'd1055 * 255);
      if (base > Unity) base = Unity;
      sq = fx_mul(base, base);
      quad = fx_mul(sq, sq);
      twelfth = fx_mul(fx_mul(quad, quad), quad);
      // Fifth root by bisection: largest y whose fifth power stays at or below.
      lo = 0;
      hi = Unity;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        m2 = fx_mul(mid, mid);
        m5 = fx_mul(fx_mul(m2, m2), mid);
        if (m5 <= twelfth) lo = mid;
        else hi = mid - 1;
      end
      lin = lo;
    end
    return (lin + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  function automatic longint unsigned luminance(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned s;
    s = 64'd13933 * gamma_lut[r] + 64'd46871 * gamma_lut[g] + 64'd4732 * gamma_lut[b];
    return (s + 64'd32768) >> 16;
  endfunction

  function automatic ratio_t predict_ratio(logic [7:0] r1, logic [7:0] g1, logic [7:0] b1,
                                           logic [7:0] r2, logic [7:0] g2, logic [7:0] b2);
    longint unsigned l1, l2, lighter, darker, bias, num, den, q;
    ratio_t res;
    l1 = luminance(r1, g1, b1);
    l2 = luminance(r2, g2, b2);
    if (l1 > l2) begin
      lighter = l1;
      darker = l2;
    end else begin
      lighter = l2;
      darker = l1;
    end
    bias = (64'd5 * (64'd1 << FRAC_BITS) + 50) / 100;
    num = (lighter + bias) << FRAC_BITS;
    den = darker + bias;
    q = (num + den / 2) / den;
    // Ratios above 21 saturate.
    if (q > (64'd21 << FRAC_BITS)) q = 64'd21 << FRAC_BITS;
    res.contrast = q[FRAC_BITS+4:0];
    res.luma_a = l1[FRAC_BITS:0];
    res.luma_b = l2[FRAC_BITS:0];
    res.a_lighter = (l1 > l2);
    return res;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) gamma_lut[i] = decode_srgb(i);
  end

  assign pending_o = ratio_q.size();

  // Predict on every input beat and compare on every output beat.
  always @(posedge clk_i) begin
    ratio_t exp_r;
    if (!rst_ni) begin
      err_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        ratio_q.push_back(predict_ratio(first_red_i, first_green_i, first_blue_i,
                                        second_red_i, second_green_i, second_blue_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (ratio_q.size() == 0) begin
          $display("%0t: unexpected output beat contrast=%0d", $time, contrast_i);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_r = ratio_q.pop_front();
          if (exp_r.contrast !== contrast_i || exp_r.luma_a !== first_luma_i ||
              exp_r.luma_b !== second_luma_i || exp_r.a_lighter !== first_is_lighter_i) begin
            $display("%0t: mismatch expected contrast=%0d l1=%0d l2=%0d lighter=%0d",
                     $time, exp_r.contrast, exp_r.luma_a, exp_r.luma_b, exp_r.a_lighter);
            $display("%0t:          actual   contrast=%0d l1=%0d l2=%0d lighter=%0d",
                     $time, contrast_i, first_luma_i, second_luma_i, first_is_lighter_i);
            err_count_o <= err_count_o + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/contrast_ratio_srgb_top_test.sv =====
`default_nettype none
module contrast_ratio_srgb_top_test;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NumRandom = 1925;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           r1, g1, b1, r2, g2, b2;
  logic                 out_valid;
  logic                 out_ready;
  logic [FRAC_BITS+4:0] contrast;
  logic [FRAC_BITS:0]   luma1, luma2;
  logic                 lighter;
  int                   err_count;
  int                   pending;
  int                   burst;
  bit                   stim_done;

  contrast_ratio_srgb_top #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .first_red_i(r1), .first_green_i(g1), .first_blue_i(b1),
    .second_red_i(r2), .second_green_i(g2), .second_blue_i(b2),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .contrast_o(contrast), .first_luma_o(luma1), .second_luma_o(luma2),
    .first_is_lighter_o(lighter)
  );

  contrast_ratio_srgb_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .first_red_i(r1), .first_green_i(g1), .first_blue_i(b1),
    .second_red_i(r2), .second_green_i(g2), .second_blue_i(b2),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .contrast_i(contrast), .first_luma_i(luma1), .second_luma_i(luma2),
    .first_is_lighter_i(lighter),
    .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Send one color pair, idling first for a random gap unless in a burst.
  task automatic send_pair(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                           logic [7:0] d, logic [7:0] e, logic [7:0] f);
    int gap;
    if (burst > 0) begin
      burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 19) == 0) burst = $urandom_range(5, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    r1 <= a; g1 <= b; b1 <= c;
    r2 <= d; g2 <= e; b2 <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  // Pick a channel code, leaning on the extremes and the linear-segment edge.
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(9, 12));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: random stalls before each beat, with no-stall runs.
  initial begin
    int stall;
    int free_run;
    out_ready <= 1'b0;
    free_run = 0;
    @(posedge rst_n);
    forever begin
      if (free_run > 0) begin
        free_run--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 19) == 0) free_run = $urandom_range(5, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus.
  initial begin
    logic [7:0] x, y, z;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    r1 <= '0; g1 <= '0; b1 <= '0;
    r2 <= '0; g2 <= '0; b2 <= '0;
    burst = 0;
    stim_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: black and white both ways, equal colors, segment boundary, single bits.
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_pair(8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11);
    send_pair(8'd11, 8'd11, 8'd11, 8'd10, 8'd10, 8'd10);
    send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
    send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
    send_pair(8'd128, 8'd64, 8'd32, 8'd128, 8'd64, 8'd32);
    send_pair(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 8; i++) begin
      send_pair(8'(1 << i), 8'(1 << i), 8'(1 << i), 8'hff ^ 8'(1 << i), 8'd0, 8'hff);
    end
    send_pair(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
    send_pair(8'd254, 8'd254, 8'd254, 8'd1, 8'd1, 8'd1);

    // Random pairs, some with equal colors.
    for (int i = 0; i < NumRandom; i++) begin
      x = pick_code();
      y = pick_code();
      z = pick_code();
      if ($urandom_range(0, 9) == 0) send_pair(x, y, z, x, y, z);
      else send_pair(x, y, z, pick_code(), pick_code(), pick_code());
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Verdict once every expected beat has arrived and the pipeline has drained.
  // The first edges let the checker record the last input beat.
  initial begin
    wait (stim_done);
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/crs_pkg.sv
rtl/crs_front.sv
rtl/crs_fifo.sv
rtl/crs_back.sv
rtl/contrast_ratio_srgb_top.sv
sim/contrast_ratio_srgb_checker.sv
sim/contrast_ratio_srgb_top_test.sv
